@@ design/hsl_hsv_to_rgb_converter_top_macros.svh @@
// Assertion macros shared by the HSL/HSV to RGB converter RTL.
`ifndef HSL_HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`define HSL_HSV_TO_RGB_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HSLHSV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hslhsv assertion failed");
`define HSLHSV_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hslhsv reset assertion failed");
`else
`define HSLHSV_ASSERT(lbl, clk, rst_n, prop)
`define HSLHSV_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ design/hslhsv_pkg.sv @@
// Types and constants for the HSL/HSV to RGB converter.
package hslhsv_pkg;

    localparam int W_HUE   = 9;
    localparam int W_PCT   = 7;
    localparam int W_CHAN  = 8;
    localparam int W_CN    = 14;  // chroma numerator, up to 10000
    localparam int W_TRI   = 6;   // triangle wave, 0..60
    localparam int W_LIN   = 20;  // channel value over 600000
    localparam int W_SCL   = 25;  // scaled and biased channel value
    localparam int W_RCP   = 18;
    localparam int RCP_SHIFT = 34;
    localparam int W_PROD  = W_SCL + W_RCP;
    localparam int W_QEST  = 9;

    localparam logic [W_PCT-1:0]  PCT_FULL   = 7'd100;
    localparam logic [W_PCT-1:0]  PCT_HALF   = 7'd50;
    localparam logic [W_HUE-1:0]  DEG_60     = 9'd60;
    localparam logic [W_HUE-1:0]  DEG_120    = 9'd120;
    localparam logic [W_HUE-1:0]  DEG_180    = 9'd180;
    localparam logic [W_HUE-1:0]  DEG_240    = 9'd240;
    localparam logic [W_HUE-1:0]  DEG_300    = 9'd300;
    localparam logic [W_HUE-1:0]  DEG_360    = 9'd360;

    // channel = floor((v * 51 + 60000) / 120000), v over 600000
    localparam logic [5:0]        CHAN_GAIN  = 6'd51;
    localparam logic [W_SCL-1:0]  ROUND_BIAS = 25'd60000;
    localparam logic [16:0]       CHAN_DIV   = 17'd120000;
    localparam logic [W_RCP-1:0]  CHAN_RCP   = 18'd143165;  // floor(2^34 / 120000)
    localparam logic [W_QEST-1:0] CHAN_MAX   = 9'd255;

    typedef enum logic [2:0] {
        SEXT_RG   = 3'd0,  // red = C, green = X
        SEXT_GR   = 3'd1,
        SEXT_GB   = 3'd2,
        SEXT_BG   = 3'd3,
        SEXT_BR   = 3'd4,
        SEXT_RB   = 3'd5,
        SEXT_GRAY = 3'd6
    } t_sextant;

    typedef struct packed {
        logic [W_LIN-1:0] c;
        logic [W_LIN-1:0] x;
        logic [W_LIN-1:0] m;
        t_sextant         sext;
    } t_chroma;

endpackage

@@ design/hslhsv_chroma.sv @@
// Front pipeline: input clamp, hue sextant, chroma, X and offset (three stages).
module hslhsv_chroma
    import hslhsv_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_source_space,
    input  logic [W_HUE-1:0] i_hue_degrees,
    input  logic [W_PCT-1:0] i_saturation_pct,
    input  logic [W_PCT-1:0] i_level_pct,
    output t_chroma          o_chroma
);

    // stage 1
    logic [W_PCT-1:0] n_a, r_a, n_sat, r_sat, n_lev, r_lev;
    logic [W_TRI-1:0] n_tri, r1_tri;
    t_sextant         n_sext, r1_sext;
    logic             r1_mode;

    logic [W_PCT-1:0] sat_c, lev_c, dev;
    logic [W_HUE-1:0] h120, hue_gap;

    always_comb begin
        sat_c = (i_saturation_pct > PCT_FULL) ? PCT_FULL : i_saturation_pct;
        lev_c = (i_level_pct > PCT_FULL) ? PCT_FULL : i_level_pct;
        if (lev_c >= PCT_HALF) begin
            dev = W_PCT'({lev_c, 1'b0} - {1'b0, PCT_FULL});
        end else begin
            dev = W_PCT'({1'b0, PCT_FULL} - {lev_c, 1'b0});
        end
        n_a   = i_source_space ? lev_c : PCT_FULL - dev;
        n_sat = sat_c;
        n_lev = lev_c;

        if (i_hue_degrees >= DEG_360) begin
            h120 = i_hue_degrees - DEG_360;
        end else if (i_hue_degrees >= DEG_240) begin
            h120 = i_hue_degrees - DEG_240;
        end else if (i_hue_degrees >= DEG_120) begin
            h120 = i_hue_degrees - DEG_120;
        end else begin
            h120 = i_hue_degrees;
        end
        hue_gap = (h120 >= DEG_60) ? h120 - DEG_60 : DEG_60 - h120;
        n_tri   = W_TRI'(DEG_60 - hue_gap);

        if (i_hue_degrees <= DEG_60) begin
            n_sext = SEXT_RG;
        end else if (i_hue_degrees <= DEG_120) begin
            n_sext = SEXT_GR;
        end else if (i_hue_degrees <= DEG_180) begin
            n_sext = SEXT_GB;
        end else if (i_hue_degrees <= DEG_240) begin
            n_sext = SEXT_BG;
        end else if (i_hue_degrees <= DEG_300) begin
            n_sext = SEXT_BR;
        end else if (i_hue_degrees <= DEG_360) begin
            n_sext = SEXT_RB;
        end else begin
            n_sext = SEXT_GRAY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= n_a;
            r_sat   <= n_sat;
            r_lev   <= n_lev;
            r1_tri  <= n_tri;
            r1_sext <= n_sext;
            r1_mode <= i_source_space;
        end
    end

    // stage 2: chroma numerator, C = cn / 10000
    logic [W_CN-1:0]  n_cn, r_cn;
    logic [W_PCT-1:0] r2_lev;
    logic [W_TRI-1:0] r2_tri;
    t_sextant         r2_sext;
    logic             r2_mode;

    assign n_cn = W_CN'(r_a * r_sat);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cn    <= n_cn;
            r2_lev  <= r_lev;
            r2_tri  <= r1_tri;
            r2_sext <= r1_sext;
            r2_mode <= r1_mode;
        end
    end

    // stage 3: values over 600000
    t_chroma          n_chroma, r_chroma;
    logic [14:0]      off_hsl;
    logic [13:0]      off_hsv;

    always_comb begin
        off_hsl    = 15'(r2_lev * 8'd200) - {1'b0, r_cn};
        off_hsv    = 14'(r2_lev * 7'd100) - r_cn;
        n_chroma.c = W_LIN'(r_cn * 6'd60);
        n_chroma.x = W_LIN'(r_cn * r2_tri);
        n_chroma.m = r2_mode ? W_LIN'(off_hsv * 6'd60) : W_LIN'(off_hsl * 5'd30);
        n_chroma.sext = r2_sext;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_chroma = r_chroma;

endmodule

@@ design/hslhsv_quant.sv @@
// Back pipeline for one channel: scale by 255/600000 with round half up (three stages).
module hslhsv_quant
    import hslhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [W_LIN-1:0]  i_lin,
    output logic [W_CHAN-1:0] o_chan
);

    logic [W_SCL-1:0]  n_scl, r_scl, r2_scl;
    logic [W_PROD-1:0] prod;
    logic [W_QEST-1:0] n_qest, r_qest;
    logic [W_SCL-1:0]  back, rem;
    logic [W_QEST-1:0] q;
    logic [W_CHAN-1:0] n_chan, r_chan;

    assign n_scl = W_SCL'(i_lin * CHAN_GAIN) + ROUND_BIAS;

    // reciprocal estimate, low by at most one
    assign prod   = W_PROD'(r_scl * CHAN_RCP);
    assign n_qest = prod[RCP_SHIFT +: W_QEST];

    always_comb begin
        back = W_SCL'(r_qest * CHAN_DIV);
        rem  = r2_scl - back;
        q    = (rem >= W_SCL'(CHAN_DIV)) ? r_qest + 1'b1 : r_qest;
        n_chan = (q > CHAN_MAX) ? CHAN_MAX[W_CHAN-1:0] : q[W_CHAN-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_scl  <= n_scl;
            r2_scl <= r_scl;
            r_qest <= n_qest;
            r_chan <= n_chan;
        end
    end

    assign o_chan = r_chan;

endmodule

@@ design/hsl_hsv_to_rgb_converter_top.sv @@
// HSL/HSV to 8-bit RGB converter, top level.
// Throughput: one word per cycle; the seven-stage pipeline advances whenever
// the output register is empty or taken, so a stall freezes every stage.
// Reset (synchronous, active low) empties the pipeline and sets source_space to HSL.
`include "hsl_hsv_to_rgb_converter_top_macros.svh"
module hsl_hsv_to_rgb_converter_top
    import hslhsv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_source_space,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [W_HUE-1:0]  i_hue_degrees,
    input  logic [W_PCT-1:0]  i_saturation_pct,
    input  logic [W_PCT-1:0]  i_level_pct,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [W_CHAN-1:0] o_red,
    output logic [W_CHAN-1:0] o_green,
    output logic [W_CHAN-1:0] o_blue
);

    localparam int N_STAGES = 7;

    logic                r_source_space;
    logic [N_STAGES-1:0] r_vld, n_vld;
    logic                en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_space <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_source_space <= i_cfg_source_space;
        end
    end

    assign en      = !(r_vld[N_STAGES-1] && i_stall);
    assign o_stall = !en;
    assign n_vld   = {r_vld[N_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    t_chroma chroma;

    hslhsv_chroma u_chroma (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_source_space   (r_source_space),
        .i_hue_degrees    (i_hue_degrees),
        .i_saturation_pct (i_saturation_pct),
        .i_level_pct      (i_level_pct),
        .o_chroma         (chroma)
    );

    // stage 4: place chroma and X on channels, add offset
    logic [W_LIN-1:0] pr, pg, pb;
    logic [W_LIN-1:0] n_lin_r, n_lin_g, n_lin_b, r_lin_r, r_lin_g, r_lin_b;

    always_comb begin
        pr = '0;
        pg = '0;
        pb = '0;
        case (chroma.sext)
            SEXT_RG: begin
                pr = chroma.c;
                pg = chroma.x;
            end
            SEXT_GR: begin
                pr = chroma.x;
                pg = chroma.c;
            end
            SEXT_GB: begin
                pg = chroma.c;
                pb = chroma.x;
            end
            SEXT_BG: begin
                pg = chroma.x;
                pb = chroma.c;
            end
            SEXT_BR: begin
                pr = chroma.x;
                pb = chroma.c;
            end
            SEXT_RB: begin
                pr = chroma.c;
                pb = chroma.x;
            end
            default: begin
                pr = '0;
            end
        endcase
        n_lin_r = pr + chroma.m;
        n_lin_g = pg + chroma.m;
        n_lin_b = pb + chroma.m;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lin_r <= n_lin_r;
            r_lin_g <= n_lin_g;
            r_lin_b <= n_lin_b;
        end
    end

    hslhsv_quant u_quant_r (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lin  (r_lin_r),
        .o_chan (o_red)
    );

    hslhsv_quant u_quant_g (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lin  (r_lin_g),
        .o_chan (o_green)
    );

    hslhsv_quant u_quant_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_lin  (r_lin_b),
        .o_chan (o_blue)
    );

    assign o_valid = r_vld[N_STAGES-1];

    `HSLHSV_ASSERT_RST(a_reset_empties, i_clk, !i_rst_n |=> !o_valid)
    `HSLHSV_ASSERT(a_accept_enters, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_vld[0])
    `HSLHSV_ASSERT(a_stall_freezes, i_clk, i_rst_n, (o_valid && i_stall) |=> $stable(r_vld))

endmodule
